/* rtl/core/integer_alu_with_magnitude_macros.svh */
// Assertion macros used by the integer ALU top level.
`ifndef INTEGER_ALU_WITH_MAGNITUDE_MACROS_SVH
`define INTEGER_ALU_WITH_MAGNITUDE_MACROS_SVH

// Same-cycle implication, checked on every clock once reset is released.
`define IALU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock once reset is released.
`define IALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ialu_pkg.sv */
// Package with widths, operation codes and the pipeline record of the integer ALU.
`default_nettype none
package ialu_pkg;

    localparam int DW    = 32;
    localparam int RAD_W = 2 * DW;
    localparam int SREM_W = DW + 2;
    localparam int ITER  = DW;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MAG = 3'd4;

    localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};

    // Record carried through the shared divide and square root stages.
    typedef struct packed {
        logic [2:0]        op;
        logic [DW-1:0]     res;
        logic              err;
        logic              neg;
        logic [DW-1:0]     dvs;
        logic [DW-1:0]     dvd;
        logic [DW:0]       drem;
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] srem;
        logic [DW-1:0]     root;
    } t_work;

endpackage
`default_nettype wire

/* rtl/core/ialu_iter_stage.sv */
// One pipeline stage holding one restoring divide step and one square root step.
`default_nettype none
module ialu_iter_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ialu_pkg::t_work i_work,
    output logic            o_valid,
    input  logic            i_ready,
    output ialu_pkg::t_work o_work
);
    import ialu_pkg::*;

    logic              r_vld;
    t_work             r_work;
    t_work             n_work;
    logic [SREM_W-1:0] w_srem_sh;
    logic [SREM_W-1:0] w_trial;
    logic              w_sq_ge;
    logic [DW:0]       w_drem_sh;
    logic              w_dv_ge;

    // The stage takes a new transfer when empty or when its content moves on.
    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_work  = r_work;

    // Square root digit: bring down two radicand bits and try (4*root + 1).
    assign w_srem_sh = {i_work.srem[SREM_W-3:0], i_work.rad[RAD_W-1 -: 2]};
    assign w_trial   = {i_work.root, 2'b01};
    assign w_sq_ge   = (w_srem_sh >= w_trial);

    // Divide digit: bring down one dividend bit and try the divisor.
    assign w_drem_sh = {i_work.drem[DW-1:0], i_work.dvd[DW-1]};
    assign w_dv_ge   = (w_drem_sh >= {1'b0, i_work.dvs});

    always_comb begin
        n_work      = i_work;
        n_work.rad  = {i_work.rad[RAD_W-3:0], 2'b00};
        n_work.srem = w_sq_ge ? (w_srem_sh - w_trial) : w_srem_sh;
        n_work.root = {i_work.root[DW-2:0], w_sq_ge};
        n_work.drem = w_dv_ge ? (w_drem_sh - {1'b0, i_work.dvs}) : w_drem_sh;
        n_work.dvd  = {i_work.dvd[DW-2:0], w_dv_ge};
    end

    // Valid bit under reset, payload captured only on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/integer_alu_with_magnitude.sv */
// Top level of the pipelined integer ALU with rounded vector magnitude.
// The input channel (i_valid, o_ready) carries an operation code and two signed
// 32-bit operands; the output channel (o_valid, i_ready) carries the result, an
// error flag for divide by zero or quotient overflow, and a saturation flag for
// a clipped magnitude. Each item is one transfer in and one transfer out.
// From input transfer to output valid an item passes through 36 register
// stages: an input register, a stage with the multipliers, a stage that sums the
// squares, 32 stages that each retire one quotient bit and one square root bit,
// and the output register.
// Throughput is one item per cycle unless stalled; digit stages fully pipelined.
// Every stage has its own valid bit and accepts a transfer when empty or when
// its content moves on, so bubbles are squeezed out when the receiver stalls
// and a full pipeline holds all items with nothing lost or repeated.
// Reset clears all valid bits; the block accepts input in the cycle after reset.
// Add, subtract and multiply wrap; divide truncates toward zero; magnitude is
// rounded to nearest and saturates at the largest positive value.
`default_nettype none
`include "integer_alu_with_magnitude_macros.svh"
module integer_alu_with_magnitude (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_op,
    input  logic signed [ialu_pkg::DW-1:0] i_operand_a,
    input  logic signed [ialu_pkg::DW-1:0] i_operand_b,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [ialu_pkg::DW-1:0] o_result,
    output logic                          o_error,
    output logic                          o_saturated
);
    import ialu_pkg::*;

    // Stage A: operand register.
    logic             r_a_vld;
    logic [2:0]       r_a_op;
    logic [DW-1:0]    r_a_opa;
    logic [DW-1:0]    r_a_opb;
    logic             w_a_rdy;

    // Stage B: multipliers, add, subtract, magnitudes and divide checks.
    logic             r_b_vld;
    logic [2:0]       r_b_op;
    logic [DW-1:0]    r_b_res;
    logic             r_b_err;
    logic             r_b_neg;
    logic [DW-1:0]    r_b_ua;
    logic [DW-1:0]    r_b_ub;
    logic [RAD_W-1:0] r_b_sqa;
    logic [RAD_W-1:0] r_b_sqb;
    logic             w_b_rdy;
    logic [DW-1:0]    n_b_res;
    logic [DW-1:0]    n_b_ua;
    logic [DW-1:0]    n_b_ub;

    // Stage C: sum of squares, start of the digit pipeline.
    logic             r_c_vld;
    t_work            r_c_work;
    logic             w_c_rdy;

    // Digit pipeline links.
    t_work            w_work [0:ITER];
    logic             w_vld  [0:ITER];
    logic             w_rdy  [0:ITER];

    // Output register.
    logic             r_out_vld;
    logic [2:0]       r_out_op;
    logic [DW-1:0]    r_out_res;
    logic             r_out_err;
    logic             r_out_sat;
    logic             w_out_rdy;
    logic [DW-1:0]    n_out_res;
    logic             n_out_sat;
    logic [DW-1:0]    w_quot;
    logic [DW:0]      w_rnd;
    t_work            w_last;

    // Per-stage ready: take a transfer when empty or when the content moves on.
    assign w_a_rdy   = !r_a_vld || w_b_rdy;
    assign w_b_rdy   = !r_b_vld || w_c_rdy;
    assign w_c_rdy   = !r_c_vld || w_rdy[0];
    assign w_out_rdy = !r_out_vld || i_ready;
    assign o_ready   = w_a_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_a_rdy) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_rdy && i_valid) begin
            r_a_op  <= i_op;
            r_a_opa <= i_operand_a;
            r_a_opb <= i_operand_b;
        end
    end

    // Wrapping arithmetic and operand magnitudes.
    always_comb begin
        n_b_ua = r_a_opa[DW-1] ? (DW'(0) - r_a_opa) : r_a_opa;
        n_b_ub = r_a_opb[DW-1] ? (DW'(0) - r_a_opb) : r_a_opb;
        case (r_a_op)
            OP_ADD:  n_b_res = r_a_opa + r_a_opb;
            OP_SUB:  n_b_res = r_a_opa - r_a_opb;
            OP_MUL:  n_b_res = DW'(r_a_opa * r_a_opb);
            default: n_b_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_b_rdy) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_rdy && r_a_vld) begin
            r_b_op  <= r_a_op;
            r_b_res <= n_b_res;
            r_b_err <= (r_a_opb == '0) || ((r_a_opb == '1) && (r_a_opa == MIN_NEG));
            r_b_neg <= r_a_opa[DW-1] ^ r_a_opb[DW-1];
            r_b_ua  <= n_b_ua;
            r_b_ub  <= n_b_ub;
            r_b_sqa <= {{DW{1'b0}}, n_b_ua} * {{DW{1'b0}}, n_b_ua};
            r_b_sqb <= {{DW{1'b0}}, n_b_ub} * {{DW{1'b0}}, n_b_ub};
        end
    end

    // Sum of squares and initial digit state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_c_rdy) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_rdy && r_b_vld) begin
            r_c_work.op   <= r_b_op;
            r_c_work.res  <= r_b_res;
            r_c_work.err  <= r_b_err;
            r_c_work.neg  <= r_b_neg;
            r_c_work.dvs  <= r_b_ub;
            r_c_work.dvd  <= r_b_ua;
            r_c_work.drem <= '0;
            r_c_work.rad  <= r_b_sqa + r_b_sqb;
            r_c_work.srem <= '0;
            r_c_work.root <= '0;
        end
    end

    assign w_work[0] = r_c_work;
    assign w_vld[0]  = r_c_vld;

    // Digit pipeline: one quotient bit and one root bit per stage.
    for (genvar g = 0; g < ITER; g++) begin : g_iter
        ialu_iter_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_work  (w_work[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_work  (w_work[g+1])
        );
    end

    assign w_rdy[ITER] = w_out_rdy;
    assign w_last      = w_work[ITER];

    // Final sign fix, rounding and saturation.
    always_comb begin
        w_quot    = w_last.neg ? (DW'(0) - w_last.dvd) : w_last.dvd;
        w_rnd     = {1'b0, w_last.root} +
                    {{DW{1'b0}}, (w_last.srem > {2'b00, w_last.root})};
        n_out_sat = 1'b0;
        case (w_last.op) inside
            OP_ADD, OP_SUB, OP_MUL: n_out_res = w_last.res;
            OP_DIV:  n_out_res = w_last.err ? '0 : w_quot;
            OP_MAG: begin
                if (w_rnd > {1'b0, MAX_POS}) begin
                    n_out_res = MAX_POS;
                    n_out_sat = 1'b1;
                end else begin
                    n_out_res = w_rnd[DW-1:0];
                end
            end
            default: n_out_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_vld <= w_vld[ITER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && w_vld[ITER]) begin
            r_out_op  <= w_last.op;
            r_out_res <= n_out_res;
            r_out_err <= (w_last.op == OP_DIV) && w_last.err;
            r_out_sat <= n_out_sat;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_result    = r_out_res;
    assign o_error     = r_out_err;
    assign o_saturated = r_out_sat;

    // Checks on the result flags and on holding the output while stalled.
    `IALU_ASSERT_NOW(a_err_op, r_out_vld && r_out_err, r_out_op == OP_DIV, "error flag op")
    `IALU_ASSERT_NOW(a_sat_op, r_out_vld && r_out_sat, r_out_op == OP_MAG, "sat flag op")
    `IALU_ASSERT_NOW(a_sat_max, r_out_vld && r_out_sat, r_out_res == MAX_POS, "sat value")
    `IALU_ASSERT_NOW(a_err_zero, r_out_vld && r_out_err, r_out_res == '0, "error result")
    `IALU_ASSERT_NEXT(a_out_hold, r_out_vld && !i_ready, r_out_vld && $stable(r_out_res), "hold")

endmodule
`default_nettype wire
